// ===== src/mtsv_pkg.sv =====
// ----------------------------------------------------------------------------
// mtsv_pkg
// shared types and byte range constants for the text stream validator
// ----------------------------------------------------------------------------
package mtsv_pkg;

   typedef enum logic [1:0] {
      MODE_UTF8   = 2'd0,
      MODE_GB2312 = 2'd1,
      MODE_GBK    = 2'd2,
      MODE_BIG5   = 2'd3
   } encoding_mode_type;

   // sequence tracking state
   typedef struct packed {
      logic [1:0] owed;
      logic       error;
   } seq_state_type;

   localparam logic [7:0] ASCII_MAX       = 8'h7F;
   localparam logic [7:0] UTF8_CONT_LO    = 8'h80;
   localparam logic [7:0] UTF8_CONT_HI    = 8'hBF;
   localparam logic [7:0] UTF8_LEAD2_LO   = 8'hC0;
   localparam logic [7:0] UTF8_LEAD2_HI   = 8'hDF;
   localparam logic [7:0] UTF8_LEAD3_LO   = 8'hE0;
   localparam logic [7:0] UTF8_LEAD3_HI   = 8'hEF;
   localparam logic [7:0] UTF8_LEAD4_LO   = 8'hF0;
   localparam logic [7:0] UTF8_LEAD4_HI   = 8'hF7;
   localparam logic [7:0] GB2312_LEAD_LO  = 8'hA1;
   localparam logic [7:0] GB2312_LEAD_HI  = 8'hF7;
   localparam logic [7:0] GB2312_TRAIL_LO = 8'hA1;
   localparam logic [7:0] GB2312_TRAIL_HI = 8'hFE;
   localparam logic [7:0] GBK_LEAD_LO     = 8'h81;
   localparam logic [7:0] GBK_LEAD_HI     = 8'hFE;
   localparam logic [7:0] GBK_TRAIL_LO    = 8'h40;
   localparam logic [7:0] GBK_TRAIL_HI    = 8'hFE;
   localparam logic [7:0] BIG5_LEAD_LO    = 8'hA1;
   localparam logic [7:0] BIG5_LEAD_HI    = 8'hF9;
   localparam logic [7:0] BIG5_TRAILA_LO  = 8'h40;
   localparam logic [7:0] BIG5_TRAILA_HI  = 8'h7E;
   localparam logic [7:0] BIG5_TRAILB_LO  = 8'hA1;
   localparam logic [7:0] BIG5_TRAILB_HI  = 8'hFE;

endpackage

// ===== src/mtsv_classify.sv =====
// ----------------------------------------------------------------------------
// mtsv_classify
// judges one byte against the current sequence state and gives the next state
// ----------------------------------------------------------------------------
module mtsv_classify (
   input  mtsv_pkg::encoding_mode_type mode,
   input  logic [7:0]                  data_byte,
   input  mtsv_pkg::seq_state_type     state_cur,
   output mtsv_pkg::seq_state_type     state_next
);

   logic       trail_ok;
   logic       lead_ok;
   logic [1:0] lead_owed;

   always_comb begin
      unique case (mode)
         mtsv_pkg::MODE_UTF8:
            trail_ok = (data_byte >= mtsv_pkg::UTF8_CONT_LO) &&
                       (data_byte <= mtsv_pkg::UTF8_CONT_HI);
         mtsv_pkg::MODE_GB2312:
            trail_ok = (data_byte >= mtsv_pkg::GB2312_TRAIL_LO) &&
                       (data_byte <= mtsv_pkg::GB2312_TRAIL_HI);
         mtsv_pkg::MODE_GBK:
            trail_ok = (data_byte >= mtsv_pkg::GBK_TRAIL_LO) &&
                       (data_byte <= mtsv_pkg::GBK_TRAIL_HI);
         mtsv_pkg::MODE_BIG5:
            trail_ok = ((data_byte >= mtsv_pkg::BIG5_TRAILA_LO) &&
                        (data_byte <= mtsv_pkg::BIG5_TRAILA_HI)) ||
                       ((data_byte >= mtsv_pkg::BIG5_TRAILB_LO) &&
                        (data_byte <= mtsv_pkg::BIG5_TRAILB_HI));
         default:
            trail_ok = 1'b0;
      endcase
   end

   always_comb begin
      lead_ok   = 1'b0;
      lead_owed = 2'd0;
      if (data_byte <= mtsv_pkg::ASCII_MAX) begin
         lead_ok = 1'b1;
      end else begin
         unique case (mode)
            mtsv_pkg::MODE_UTF8: begin
               if ((data_byte >= mtsv_pkg::UTF8_LEAD2_LO) &&
                   (data_byte <= mtsv_pkg::UTF8_LEAD2_HI)) begin
                  lead_ok   = 1'b1;
                  lead_owed = 2'd1;
               end else if ((data_byte >= mtsv_pkg::UTF8_LEAD3_LO) &&
                            (data_byte <= mtsv_pkg::UTF8_LEAD3_HI)) begin
                  lead_ok   = 1'b1;
                  lead_owed = 2'd2;
               end else if ((data_byte >= mtsv_pkg::UTF8_LEAD4_LO) &&
                            (data_byte <= mtsv_pkg::UTF8_LEAD4_HI)) begin
                  lead_ok   = 1'b1;
                  lead_owed = 2'd3;
               end
            end
            mtsv_pkg::MODE_GB2312: begin
               lead_ok   = (data_byte >= mtsv_pkg::GB2312_LEAD_LO) &&
                           (data_byte <= mtsv_pkg::GB2312_LEAD_HI);
               lead_owed = 2'd1;
            end
            mtsv_pkg::MODE_GBK: begin
               lead_ok   = (data_byte >= mtsv_pkg::GBK_LEAD_LO) &&
                           (data_byte <= mtsv_pkg::GBK_LEAD_HI);
               lead_owed = 2'd1;
            end
            mtsv_pkg::MODE_BIG5: begin
               lead_ok   = (data_byte >= mtsv_pkg::BIG5_LEAD_LO) &&
                           (data_byte <= mtsv_pkg::BIG5_LEAD_HI);
               lead_owed = 2'd1;
            end
            default: begin
               lead_ok   = 1'b0;
               lead_owed = 2'd0;
            end
         endcase
      end
   end

   always_comb begin
      state_next = state_cur;
      if (!state_cur.error) begin
         if (state_cur.owed != 2'd0) begin
            if (trail_ok) begin
               state_next.owed = state_cur.owed - 2'd1;
            end else begin
               state_next.owed  = 2'd0;
               state_next.error = 1'b1;
            end
         end else if (lead_ok) begin
            state_next.owed = lead_owed;
         end else begin
            state_next.error = 1'b1;
         end
      end
   end

endmodule

// ===== src/mtsv_core.sv =====
// ----------------------------------------------------------------------------
// mtsv_core
// input register, sequence state and verdict register
// ----------------------------------------------------------------------------
module mtsv_core (
   input  logic                        clock,
   input  logic                        reset,
   input  mtsv_pkg::encoding_mode_type mode,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [7:0]                  req_data_byte,
   input  logic                        req_is_last,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_stream_valid
);

   logic                    stage_valid_ff;
   logic                    stage_valid_in;
   logic [7:0]              stage_byte_ff;
   logic                    stage_last_ff;
   mtsv_pkg::seq_state_type seq_ff;
   mtsv_pkg::seq_state_type seq_in;
   mtsv_pkg::seq_state_type seq_next;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   logic                    verdict_ff;
   logic                    out_free;
   logic                    stage_advance;
   logic                    req_transfer;

   mtsv_classify u_classify (
      .mode       (mode),
      .data_byte  (stage_byte_ff),
      .state_cur  (seq_ff),
      .state_next (seq_next)
   );

   assign out_free      = !rsp_valid_ff || rsp_ready;
   assign stage_advance = stage_valid_ff && (!stage_last_ff || out_free);
   assign req_ready     = !stage_valid_ff || stage_advance;
   assign req_transfer  = req_valid && req_ready;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (req_ready) begin
         stage_valid_in = req_valid;
      end
   end

   always_comb begin
      seq_in = seq_ff;
      if (stage_advance) begin
         seq_in = stage_last_ff ? '0 : seq_next;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (stage_advance && stage_last_ff) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         seq_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         seq_ff         <= seq_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_transfer) begin
         stage_byte_ff <= req_data_byte;
         stage_last_ff <= req_is_last;
      end
      if (stage_advance && stage_last_ff) begin
         verdict_ff <= !seq_next.error && (seq_next.owed == 2'd0);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_stream_valid = verdict_ff;

endmodule

// ===== src/multibyte_text_stream_validator_top.sv =====
// ----------------------------------------------------------------------------
// multibyte_text_stream_validator_top
// checks a byte stream for well formed UTF-8, GB2312, GBK or BIG5 text
// ----------------------------------------------------------------------------
// a last byte passes the byte register, then its verdict is registered in the verdict register
// throughput: one byte per cycle while no verdict waits, set by the single byte register stage
// a pending verdict not taken holds the next last-marked byte and the input behind it
// reset (synchronous, active high): mode to UTF-8, stream state and pipe clear
module multibyte_text_stream_validator_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_enable,
   input  logic [1:0] csr_write_data,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_is_last,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_stream_valid
);

   mtsv_pkg::encoding_mode_type mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= mtsv_pkg::MODE_UTF8;
      end else if (csr_write_enable) begin
         mode_ff <= mtsv_pkg::encoding_mode_type'(csr_write_data);
      end
   end

   mtsv_core u_core (
      .clock            (clock),
      .reset            (reset),
      .mode             (mode_ff),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_is_last      (req_is_last),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_stream_valid (rsp_stream_valid)
   );

endmodule

// ===== src/mtsv_checker.sv =====
// ----------------------------------------------------------------------------
// mtsv_checker
// port level checks on the validator top level
// ----------------------------------------------------------------------------
module mtsv_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_stream_valid
);

   // no verdict straight out of reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("verdict valid after reset");

   // input side is open right after reset
   a_reset_ready: assert property (@(posedge clock) reset |=> req_ready)
      else $error("input not ready after reset");

   // a stalled verdict holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_stream_valid))
      else $error("verdict dropped or changed while stalled");

   // input only backs up behind a stalled verdict
   a_ready_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled without output back-pressure");

   // a blocked request is not withdrawn
   a_no_accept_when_blocked: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid)
      else $error("request withdrawn while blocked");

endmodule

bind multibyte_text_stream_validator_top mtsv_checker u_mtsv_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_stream_valid (rsp_stream_valid)
);
